@@ design/table_driven_dfa_acceptor_macros.svh @@
// Assertion macros shared by the acceptor RTL.
`ifndef TABLE_DRIVEN_DFA_ACCEPTOR_MACROS_SVH
`define TABLE_DRIVEN_DFA_ACCEPTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TDFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TDFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tdfa_pkg.sv @@
// Package with field widths, item and verdict codes and default sizes of the acceptor.
`default_nettype none

package tdfa_pkg;

    // Field widths
    localparam int KIND_W    = 3;
    localparam int STATE_W   = 8;
    localparam int SYMBOL_W  = 8;
    localparam int VERDICT_W = 2;

    // Default table geometry
    localparam int STATES_DEF  = 256;
    localparam int SYMBOLS_DEF = 256;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TRANS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALPHA = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FINAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SYM   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EOW   = 3'd4;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD    = 2'd2;

endpackage

`default_nettype wire

@@ design/table_driven_dfa_acceptor.sv @@
// Programmable DFA acceptor: transition table memory, alphabet and final maps, word stepping.
//
//  channel   dir  handshake                 payload
//  item      in   item_valid / item_stall   kind, from_state, symbol, to_state
//  result    out  result_valid / result_stall  verdict, end_state
//  config    in   cfg_we                    cfg_wdata (start state)
//
// Transition loads, word symbols and end of word, unlike alphabet and final marks and unknown
// kinds, pass through a second state: the idle state reads the mark memory (and the transition
// memory for a symbol), the second acts on the read data and, for end of word, registers the
// result beat. After reset both memories are swept to zero, one entry a cycle, over STATES
// (capped at 256) x 2**clog2(SYMBOLS) entries (65536 by default); no beat is taken meanwhile.
// A full result register that is stalled holds off new item beats.
`default_nettype none

module table_driven_dfa_acceptor #(
    parameter int STATES  = tdfa_pkg::STATES_DEF,
    parameter int SYMBOLS = tdfa_pkg::SYMBOLS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [tdfa_pkg::STATE_W-1:0]    cfg_wdata,
    // item channel
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [tdfa_pkg::KIND_W-1:0]     kind,
    input  wire logic [tdfa_pkg::STATE_W-1:0]    from_state,
    input  wire logic [tdfa_pkg::SYMBOL_W-1:0]   symbol,
    input  wire logic [tdfa_pkg::STATE_W-1:0]    to_state,
    // result channel
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [tdfa_pkg::VERDICT_W-1:0]       verdict,
    output logic [tdfa_pkg::STATE_W-1:0]         end_state
);
    import tdfa_pkg::*;

`include "table_driven_dfa_acceptor_macros.svh"

    // Reachable states are bounded by the 8-bit state fields
    localparam int ST_EFF = (STATES < (1 << STATE_W)) ? STATES : (1 << STATE_W);
    localparam int ST_W   = (ST_EFF > 1) ? $clog2(ST_EFF) : 1;
    localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int AW     = ST_W + SYM_W;
    localparam int DEPTH  = ST_EFF << SYM_W;

    // Mark memory: alphabet bits first, final-state bits after them
    localparam int MAP_DEPTH = SYMBOLS + ST_EFF;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam logic [MAP_AW-1:0] FINAL_BASE = MAP_AW'(SYMBOLS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_LOAD,
        ST_EOW
    } fsm_t;

    fsm_t                   state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [STATE_W-1:0]     start_reg, start_next;
    logic [STATE_W-1:0]     cur_reg, cur_next;
    logic                   in_word_reg, in_word_next;
    logic                   bad_reg, bad_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic [ST_W-1:0]        pend_to_reg, pend_to_next;
    logic                   pend_ok_reg, pend_ok_next;
    logic                   pend_walk_reg, pend_walk_next;
    logic                   res_valid_reg, res_valid_next;
    logic [VERDICT_W-1:0]   verdict_reg, verdict_next;
    logic [STATE_W-1:0]     end_state_reg, end_state_next;

    // Transition memory
    logic [ST_W-1:0]        trans_mem [DEPTH];
    logic [ST_W-1:0]        rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [ST_W-1:0]        mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    // Mark memory
    logic                   map_mem [MAP_DEPTH];
    logic                   map_rdata_reg;
    logic                   map_we;
    logic [MAP_AW-1:0]      map_waddr;
    logic                   map_wdata;
    logic                   map_re;
    logic [MAP_AW-1:0]      map_raddr;

    logic                   item_acc;
    logic                   sym_in_range;
    logic [STATE_W-1:0]     st_eff;
    logic [STATE_W-1:0]     fin;

    assign item_stall = (state_reg != ST_IDLE) || (res_valid_reg && result_stall);
    assign item_acc   = item_valid && !item_stall;

    // Word state as seen by this beat: a fresh word starts from the start register
    assign st_eff       = in_word_reg ? cur_reg : start_reg;
    assign fin          = st_eff;
    assign sym_in_range = (32'(symbol) < SYMBOLS);

    // Transition memory port: clear sweep, deferred transition load, table read
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = pend_to_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_LOAD && pend_ok_reg && map_rdata_reg)
        begin
            mem_we = 1'b1;
        end
        mem_raddr = {st_eff[ST_W-1:0], symbol[SYM_W-1:0]};
        mem_re    = item_acc && kind == KIND_SYM && sym_in_range && 32'(st_eff) < STATES;
    end

    // Mark memory port: clear sweep, marks, alphabet or final lookup
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = MAP_AW'(symbol[SYM_W-1:0]);
        map_wdata = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            map_we    = (32'(clr_cnt_reg) < MAP_DEPTH);
            map_waddr = clr_cnt_reg[MAP_AW-1:0];
            map_wdata = 1'b0;
        end
        else if (item_acc && kind == KIND_ALPHA && sym_in_range)
        begin
            map_we = 1'b1;
        end
        else if (item_acc && kind == KIND_FINAL && 32'(from_state) < STATES)
        begin
            map_we    = 1'b1;
            map_waddr = FINAL_BASE + MAP_AW'(from_state[ST_W-1:0]);
        end
        if (kind == KIND_EOW)
        begin
            map_raddr = FINAL_BASE + MAP_AW'(fin[ST_W-1:0]);
            map_re    = item_acc && 32'(fin) < STATES;
        end
        else
        begin
            map_raddr = MAP_AW'(symbol[SYM_W-1:0]);
            map_re    = item_acc && (kind == KIND_TRANS || kind == KIND_SYM) && sym_in_range;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            trans_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= trans_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        start_next     = cfg_we ? cfg_wdata : start_reg;
        cur_next       = cur_reg;
        in_word_next   = in_word_reg;
        bad_next       = bad_reg;
        pend_addr_next = pend_addr_reg;
        pend_to_next   = pend_to_reg;
        pend_ok_next   = pend_ok_reg;
        pend_walk_next = pend_walk_reg;
        res_valid_next = res_valid_reg && result_stall;
        verdict_next   = verdict_reg;
        end_state_next = end_state_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    unique case (kind)
                        KIND_TRANS:
                        begin
                            // written next cycle once the alphabet bit is back
                            pend_addr_next = {from_state[ST_W-1:0], symbol[SYM_W-1:0]};
                            pend_to_next   = to_state[ST_W-1:0];
                            pend_ok_next   = sym_in_range && 32'(from_state) < STATES &&
                                             32'(to_state) < STATES;
                            state_next     = ST_LOAD;
                        end
                        KIND_SYM:
                        begin
                            in_word_next   = 1'b1;
                            cur_next       = st_eff;
                            pend_ok_next   = sym_in_range;
                            pend_walk_next = (32'(st_eff) < STATES);
                            state_next     = ST_STEP;
                        end
                        KIND_EOW:
                        begin
                            end_state_next = fin;
                            pend_ok_next   = (32'(fin) < STATES);
                            state_next     = ST_EOW;
                        end
                        default:
                        begin
                            // marks go to the mark memory port; unknown kinds drop
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                // Symbol in the alphabet: table read data is the new state, or zero for an out-of-range state
                if (pend_ok_reg && map_rdata_reg)
                begin
                    if (pend_walk_reg)
                    begin
                        cur_next = STATE_W'(rdata_reg);
                    end
                    else
                    begin
                        cur_next = '0;
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_EOW:
            begin
                res_valid_next = 1'b1;
                if (bad_reg)
                begin
                    verdict_next = VERDICT_BAD;
                end
                else if (pend_ok_reg && map_rdata_reg)
                begin
                    verdict_next = VERDICT_ACCEPT;
                end
                else
                begin
                    verdict_next = VERDICT_REJECT;
                end
                in_word_next = 1'b0;
                bad_next     = 1'b0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= '0;
            cur_reg       <= '0;
            in_word_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            pend_addr_reg <= '0;
            pend_to_reg   <= '0;
            pend_ok_reg   <= 1'b0;
            pend_walk_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_REJECT;
            end_state_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            start_reg     <= start_next;
            cur_reg       <= cur_next;
            in_word_reg   <= in_word_next;
            bad_reg       <= bad_next;
            pend_addr_reg <= pend_addr_next;
            pend_to_reg   <= pend_to_next;
            pend_ok_reg   <= pend_ok_next;
            pend_walk_reg <= pend_walk_next;
            res_valid_reg <= res_valid_next;
            verdict_reg   <= verdict_next;
            end_state_reg <= end_state_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign verdict      = verdict_reg;
    assign end_state    = end_state_reg;

    // Checks
    `TDFA_ASSERT_NEXT(a_step_one_cycle, state_reg != ST_IDLE && state_reg != ST_CLEAR,
        state_reg == ST_IDLE, "second item cycle lasted more than one cycle")
    `TDFA_ASSERT_NEXT(a_read_starts_step, mem_re, state_reg == ST_STEP,
        "table read issued without a step cycle")
    `TDFA_ASSERT_NEXT(a_eow_gives_result, state_reg == ST_EOW,
        result_valid && !in_word_reg && !bad_reg,
        "end of word did not post a result and rearm")
    `TDFA_ASSERT_NOW(a_no_write_in_step, state_reg == ST_STEP, !mem_we && !item_acc,
        "memory write or beat taken during a table step")
    `TDFA_ASSERT_NOW(a_map_one_access, map_re, !map_we,
        "mark memory read and written in the same cycle")

endmodule

`default_nettype wire
